@@ rtl/core/assert_macros.svh @@
// Shared assertion macros for the block's checkers.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SWMMM_ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SWMMM_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/core/swmmm_pkg.sv @@
`timescale 1ns / 1ps

package swmmm_pkg;

	localparam int SAMPLE_BITS = 16;
	localparam int MAX_WINDOW  = 2048;
	localparam int ADDR_BITS   = $clog2(MAX_WINDOW);
	localparam int LEN_BITS    = 12;
	// window sum grows by one bit per doubling of the window, plus sign
	localparam int SUM_BITS    = SAMPLE_BITS + ADDR_BITS + 1;
	localparam int STEP_BITS   = $clog2(SUM_BITS);

	localparam logic [LEN_BITS-1:0] LEN_RESET = LEN_BITS'(600);

	localparam logic OP_PUSH  = 1'b0;
	localparam logic OP_CLEAR = 1'b1;

	typedef struct packed {
		logic                          op;
		logic signed [SAMPLE_BITS-1:0] sample;
	} item_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] window_min;
		logic signed [SAMPLE_BITS-1:0] window_max;
		logic signed [SAMPLE_BITS-1:0] window_mean;
		logic signed [SAMPLE_BITS-1:0] newest_sample;
	} result_t;

	typedef struct packed {
		logic                start;
		logic [SUM_BITS-1:0] dividend;
		logic [LEN_BITS-1:0] divisor;
	} div_req_t;

endpackage

@@ rtl/core/sliding_window_min_max_mean_unit.sv @@
`timescale 1ns / 1ps

// Sliding window min / max / mean over a signed 16-bit sample stream held in
// a 2048-entry ring memory. A push beat stores the sample, then reads the
// last window_length entries (clamped to 1..2048) back one per cycle (single
// read port, registered read data) while min, max and sum accumulate, and
// divides the sum by the length in an iterative divider at one quotient bit
// per cycle. A clear beat writes the sample into all 2048 entries through the
// single write port, one per cycle. After reset the same sweep zeroes the
// ring, and item_stall stays high until it ends. cfg_ready is always high;
// write window_length only while the block is idle and follow it by a clear.
// The result sits in an output register, so the next item is taken while a
// result is still stalled.

module sliding_window_min_max_mean_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            item_valid,
	output logic                            item_stall,
	input  swmmm_pkg::item_t                item,
	output logic                            result_valid,
	input  logic                            result_stall,
	output swmmm_pkg::result_t              result,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [swmmm_pkg::LEN_BITS-1:0]  cfg_data
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_FILL = 3'd1;
	localparam logic [2:0] ST_SCAN = 3'd2;
	localparam logic [2:0] ST_DIV  = 3'd3;
	localparam logic [2:0] ST_EMIT = 3'd4;

	logic [2:0]                                state_q;
	logic [swmmm_pkg::LEN_BITS-1:0]            win_len_q;
	logic [swmmm_pkg::LEN_BITS-1:0]            eff_len;
	logic [swmmm_pkg::ADDR_BITS-1:0]           wp_q;
	logic [swmmm_pkg::LEN_BITS-1:0]            cnt_q;
	logic [swmmm_pkg::ADDR_BITS-1:0]           rd_addr_q;
	logic                                      rd_pend_s1;
	logic signed [swmmm_pkg::SAMPLE_BITS-1:0]  fill_val_q;
	logic                                      emit_fill_q;
	logic signed [swmmm_pkg::SAMPLE_BITS-1:0]  newest_q;
	logic signed [swmmm_pkg::SAMPLE_BITS-1:0]  lo_q;
	logic signed [swmmm_pkg::SAMPLE_BITS-1:0]  hi_q;
	logic signed [swmmm_pkg::SUM_BITS-1:0]     sum_q;
	swmmm_pkg::result_t                        pend_q;
	swmmm_pkg::result_t                        result_q;
	logic                                      result_valid_q;

	logic [swmmm_pkg::SAMPLE_BITS-1:0]         ring_mem [swmmm_pkg::MAX_WINDOW];
	logic signed [swmmm_pkg::SAMPLE_BITS-1:0]  rd_data_s1;

	logic                                      mem_we;
	logic [swmmm_pkg::ADDR_BITS-1:0]           mem_waddr;
	logic [swmmm_pkg::SAMPLE_BITS-1:0]         mem_wdata;

	logic                                      item_beat;
	logic                                      push_beat;
	logic                                      clear_beat;
	logic                                      fill_last;
	logic                                      scan_issue;
	logic                                      scan_end;
	logic                                      emit_load;

	swmmm_pkg::div_req_t                       div_req;
	logic                                      div_done;
	logic [swmmm_pkg::SUM_BITS-1:0]            div_quot;
	logic [swmmm_pkg::SAMPLE_BITS-1:0]         mean_mag;
	logic signed [swmmm_pkg::SAMPLE_BITS-1:0]  mean;

	// clamp the configured length to 1..MAX_WINDOW
	always_comb begin
		eff_len = win_len_q;
		if (win_len_q == '0) begin
			eff_len = swmmm_pkg::LEN_BITS'(1);
		end else if (win_len_q > swmmm_pkg::LEN_BITS'(swmmm_pkg::MAX_WINDOW)) begin
			eff_len = swmmm_pkg::LEN_BITS'(swmmm_pkg::MAX_WINDOW);
		end
	end

	// handshake and sequencing events
	assign item_stall = (state_q != ST_IDLE);
	assign item_beat  = item_valid && !item_stall;
	assign push_beat  = item_beat && (item.op == swmmm_pkg::OP_PUSH);
	assign clear_beat = item_beat && (item.op == swmmm_pkg::OP_CLEAR);
	assign fill_last  = (state_q == ST_FILL)
	                    && (cnt_q[swmmm_pkg::ADDR_BITS-1:0]
	                        == swmmm_pkg::ADDR_BITS'(swmmm_pkg::MAX_WINDOW - 1));
	assign scan_issue = (state_q == ST_SCAN) && (cnt_q != '0);
	assign scan_end   = (state_q == ST_SCAN) && (cnt_q == '0) && !rd_pend_s1;
	assign emit_load  = (state_q == ST_EMIT) && (!result_valid_q || !result_stall);

	// ring write port: fill sweep or the pushed sample
	assign mem_we    = (state_q == ST_FILL) || push_beat;
	assign mem_waddr = (state_q == ST_FILL) ? cnt_q[swmmm_pkg::ADDR_BITS-1:0] : wp_q;
	assign mem_wdata = (state_q == ST_FILL) ? fill_val_q : item.sample;

	// ring memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			ring_mem[mem_waddr] <= mem_wdata;
		end
		rd_data_s1 <= ring_mem[rd_addr_q];
	end

	// start the divide on the magnitude of the finished sum
	always_comb begin
		div_req.start    = scan_end;
		div_req.dividend = sum_q[swmmm_pkg::SUM_BITS-1] ? swmmm_pkg::SUM_BITS'(-sum_q)
		                                                : swmmm_pkg::SUM_BITS'(sum_q);
		div_req.divisor  = eff_len;
	end

	swmmm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.done   (div_done),
		.quot   (div_quot)
	);

	// restore the sign of the truncated quotient
	assign mean_mag = div_quot[swmmm_pkg::SAMPLE_BITS-1:0];
	assign mean     = sum_q[swmmm_pkg::SUM_BITS-1] ? -$signed(mean_mag) : $signed(mean_mag);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_FILL;
			win_len_q      <= swmmm_pkg::LEN_RESET;
			wp_q           <= '0;
			cnt_q          <= '0;
			rd_pend_s1     <= 1'b0;
			fill_val_q     <= '0;
			emit_fill_q    <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				win_len_q <= cfg_data;
			end
			rd_pend_s1 <= scan_issue;
			// raise valid on a new result, drop it once the beat is taken
			if (emit_load) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (clear_beat) begin
						fill_val_q  <= item.sample;
						emit_fill_q <= 1'b1;
						cnt_q       <= '0;
						state_q     <= ST_FILL;
					end else if (push_beat) begin
						wp_q    <= wp_q + 1'b1;
						cnt_q   <= eff_len;
						state_q <= ST_SCAN;
					end
				end
				ST_FILL: begin
					cnt_q <= cnt_q + 1'b1;
					if (fill_last) begin
						emit_fill_q <= 1'b0;
						state_q     <= emit_fill_q ? ST_EMIT : ST_IDLE;
					end
				end
				ST_SCAN: begin
					if (scan_issue) begin
						cnt_q <= cnt_q - 1'b1;
					end
					if (scan_end) begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (emit_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath: read address, running statistics, pending and output result
	always_ff @(posedge clk) begin
		if (push_beat) begin
			newest_q  <= item.sample;
			rd_addr_q <= wp_q;
			lo_q      <= item.sample;
			hi_q      <= item.sample;
			sum_q     <= '0;
		end else if (clear_beat) begin
			newest_q <= item.sample;
		end
		if (scan_issue) begin
			rd_addr_q <= rd_addr_q - 1'b1;
		end
		if (rd_pend_s1) begin
			lo_q  <= (rd_data_s1 < lo_q) ? rd_data_s1 : lo_q;
			hi_q  <= (rd_data_s1 > hi_q) ? rd_data_s1 : hi_q;
			sum_q <= sum_q + swmmm_pkg::SUM_BITS'(rd_data_s1);
		end
		if (fill_last) begin
			pend_q.window_min    <= fill_val_q;
			pend_q.window_max    <= fill_val_q;
			pend_q.window_mean   <= fill_val_q;
			pend_q.newest_sample <= fill_val_q;
		end else if ((state_q == ST_DIV) && div_done) begin
			pend_q.window_min    <= lo_q;
			pend_q.window_max    <= hi_q;
			pend_q.window_mean   <= mean;
			pend_q.newest_sample <= newest_q;
		end
		if (emit_load) begin
			result_q <= pend_q;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;
	assign cfg_ready    = 1'b1;

endmodule

@@ rtl/core/swmmm_div.sv @@
`timescale 1ns / 1ps

module swmmm_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  swmmm_pkg::div_req_t          req,
	output logic                         done,
	output logic [swmmm_pkg::SUM_BITS-1:0] quot
);

	logic                             busy_q;
	logic                             done_q;
	logic [swmmm_pkg::STEP_BITS-1:0]  step_q;
	logic [swmmm_pkg::LEN_BITS-1:0]   rem_q;
	logic [swmmm_pkg::LEN_BITS-1:0]   div_q;
	logic [swmmm_pkg::SUM_BITS-1:0]   quot_q;
	logic [swmmm_pkg::LEN_BITS:0]     rem_sh;
	logic [swmmm_pkg::LEN_BITS:0]     rem_sub;
	logic                             fits;

	// one restoring step: shift in the next dividend bit, try the subtract
	assign rem_sh  = {rem_q, quot_q[swmmm_pkg::SUM_BITS-1]};
	assign rem_sub = rem_sh - {1'b0, div_q};
	assign fits    = (rem_sh >= {1'b0, div_q});

	// control: run one bit per cycle, pulse done after the last bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= busy_q && !req.start && (step_q == '0);
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= swmmm_pkg::STEP_BITS'(swmmm_pkg::SUM_BITS - 1);
			end else if (busy_q) begin
				step_q <= step_q - 1'b1;
				if (step_q == '0) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// datapath: quotient bits replace dividend bits as they shift out
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q  <= '0;
			div_q  <= req.divisor;
			quot_q <= req.dividend;
		end else if (busy_q) begin
			rem_q  <= fits ? rem_sub[swmmm_pkg::LEN_BITS-1:0]
			               : rem_sh[swmmm_pkg::LEN_BITS-1:0];
			quot_q <= {quot_q[swmmm_pkg::SUM_BITS-2:0], fits};
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule

@@ rtl/core/swmmm_checker.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"

module swmmm_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	input  logic               item_stall,
	input  logic               result_valid,
	input  logic               result_stall,
	input  swmmm_pkg::result_t result
);

	logic item_beat;
	logic res_hold;
	logic min_ok;
	logic new_ok;

	assign item_beat = item_valid && !item_stall;
	assign res_hold  = result_valid && result_stall;
	// statistics must be ordered: min <= mean <= max, newest within the window
	assign min_ok = ($signed(result.window_min) <= $signed(result.window_mean))
	                && ($signed(result.window_mean) <= $signed(result.window_max));
	assign new_ok = ($signed(result.window_min) <= $signed(result.newest_sample))
	                && ($signed(result.newest_sample) <= $signed(result.window_max));

	`SWMMM_ASSERT_NEXT(a_res_hold, clk, arst_n, res_hold, result_valid && $stable(result), "stalled result changed")
	`SWMMM_ASSERT_NEXT(a_busy_after_item, clk, arst_n, item_beat, item_stall, "input open after item beat")
	`SWMMM_ASSERT_IMPLY(a_mean_order, clk, arst_n, result_valid, min_ok, "mean outside min..max")
	`SWMMM_ASSERT_IMPLY(a_newest_order, clk, arst_n, result_valid, new_ok, "newest outside min..max")

endmodule

bind sliding_window_min_max_mean_unit swmmm_checker u_swmmm_checker (.*);

@@ test/tb_sliding_window_min_max_mean_unit.sv @@
`timescale 1ns / 1ps

module tb_sliding_window_min_max_mean_unit;
	import swmmm_pkg::*;

	localparam int CLK_HALF       = 5;
	localparam int QUIET_LIMIT    = 20000;
	localparam int HOLDOFF_CYCLES = 700;
	localparam int DRAIN_CYCLES   = 2100;
	localparam int ERROR_PRINTS   = 50;

	// clock and reset
	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	always #CLK_HALF clk = ~clk;

	// block ports
	logic                item_valid   = 1'b0;
	logic                item_stall;
	item_t               item         = '0;
	logic                result_valid;
	logic                result_stall = 1'b0;
	result_t             result;
	logic                cfg_valid    = 1'b0;
	logic                cfg_ready;
	logic [LEN_BITS-1:0] cfg_data     = '0;

	sliding_window_min_max_mean_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	// shadow copy of the window state
	logic signed [SAMPLE_BITS-1:0] shadow_ring [MAX_WINDOW] = '{default: '0};
	logic [ADDR_BITS-1:0]          shadow_wpos = '0;
	logic [LEN_BITS-1:0]           shadow_len  = LEN_RESET;

	// traffic bookkeeping
	item_t       pending_items [$];
	result_t     stats_due [$];
	int          items_queued    = 0;
	int          items_accepted  = 0;
	int          cfg_writes      = 0;
	int          errors          = 0;
	int          quiet_cycles    = 0;
	bit          item_accepted   = 1'b0;
	bit          idle_on         = 1'b1;
	int          gap_left        = 0;
	int          stall_left      = 0;
	int          holdoff_left    = 0;
	int          holdoff_requests = 0;
	int          holdoff_seen    = 0;

	task automatic flag_error(input string msg);
		if (errors < ERROR_PRINTS)
			$display("ERROR @%0t: %s", $realtime, msg);
		errors++;
	endtask

	task automatic check_field(input string name, input logic signed [SAMPLE_BITS-1:0] got,
			input logic signed [SAMPLE_BITS-1:0] want);
		if (got !== want)
			flag_error($sformatf("%s got %0d expected %0d", name, got, want));
	endtask

	// compute window stats for one beat and advance the shadow state
	function automatic result_t predict_window_stats(input item_t beat);
		result_t                       stats;
		int unsigned                   span;
		longint                        total;
		logic signed [SAMPLE_BITS-1:0] lo;
		logic signed [SAMPLE_BITS-1:0] hi;
		logic signed [SAMPLE_BITS-1:0] v;
		logic [ADDR_BITS-1:0]          idx;
		if (beat.op == OP_CLEAR) begin
			foreach (shadow_ring[k])
				shadow_ring[k] = beat.sample;
			stats.window_min    = beat.sample;
			stats.window_max    = beat.sample;
			stats.window_mean   = beat.sample;
			stats.newest_sample = beat.sample;
			return stats;
		end
		shadow_ring[shadow_wpos] = beat.sample;
		shadow_wpos = shadow_wpos + 1'b1;
		span = shadow_len;
		if (span == 0)
			span = 1;
		if (span > MAX_WINDOW)
			span = MAX_WINDOW;
		lo    = beat.sample;
		hi    = beat.sample;
		total = 0;
		// scan newest to oldest, wrapping around the ring
		for (int k = 0; k < span; k++) begin
			idx = ADDR_BITS'(int'(shadow_wpos) - 1 - k);
			v   = shadow_ring[idx];
			if (v < lo)
				lo = v;
			if (v > hi)
				hi = v;
			total += v;
		end
		stats.window_min    = lo;
		stats.window_max    = hi;
		stats.window_mean   = SAMPLE_BITS'(total / longint'(span));
		stats.newest_sample = beat.sample;
		return stats;
	endfunction

	// monitor: sample handshakes at the rising edge
	always @(posedge clk) begin : monitor
		result_t want;
		bit      moved;
		moved = 1'b0;
		item_accepted = 1'b0;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				shadow_len = cfg_data;
				cfg_writes++;
				moved = 1'b1;
			end
			if (result_valid && !result_stall) begin
				moved = 1'b1;
				if (stats_due.size() == 0) begin
					flag_error("result beat with nothing outstanding");
				end else begin
					want = stats_due.pop_front();
					check_field("window_min", result.window_min, want.window_min);
					check_field("window_max", result.window_max, want.window_max);
					check_field("window_mean", result.window_mean, want.window_mean);
					check_field("newest_sample", result.newest_sample, want.newest_sample);
				end
			end
			if (item_valid && !item_stall) begin
				item_accepted = 1'b1;
				moved = 1'b1;
				stats_due.push_back(predict_window_stats(item));
				items_accepted++;
			end
			// watchdog on cycles without any beat
			quiet_cycles = moved ? 0 : quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("Verification failed");
				$finish;
			end
		end
	end

	// item driver: hold a stalled beat, otherwise idle or offer the next one
	always @(negedge clk) begin : item_driver
		if (!arst_n) begin
			item_valid <= 1'b0;
		end else if (item_valid && !item_accepted) begin
			// hold until taken
		end else if (gap_left > 0) begin
			gap_left--;
			item_valid <= 1'b0;
		end else if (pending_items.size() == 0) begin
			item_valid <= 1'b0;
		end else if (idle_on && $urandom_range(0, 7) == 0) begin
			gap_left = $urandom_range(1, 15) - 1;
			item_valid <= 1'b0;
		end else begin
			item       <= pending_items.pop_front();
			item_valid <= 1'b1;
		end
	end

	// result stall driver: random bursts plus a requested long hold-off
	always @(negedge clk) begin : stall_driver
		logic hold;
		if (holdoff_requests != holdoff_seen) begin
			holdoff_seen = holdoff_requests;
			holdoff_left = HOLDOFF_CYCLES;
		end
		if (holdoff_left > 0) begin
			holdoff_left--;
			hold = 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			hold = 1'b1;
		end else if (idle_on && $urandom_range(0, 7) == 0) begin
			stall_left = $urandom_range(1, 15) - 1;
			hold = 1'b1;
		end else begin
			hold = 1'b0;
		end
		result_stall <= hold;
	end

	task automatic queue_item(input logic op, input logic signed [SAMPLE_BITS-1:0] sample);
		item_t beat;
		beat.op     = op;
		beat.sample = sample;
		pending_items.push_back(beat);
		items_queued++;
	endtask

	function automatic logic signed [SAMPLE_BITS-1:0] pick_sample(input int unsigned style);
		case (style)
			0: return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
			1: return SAMPLE_BITS'(int'($urandom_range(0, 16)) - 8);
			2: return SAMPLE_BITS'($urandom_range(32700, 32767));
			3: return SAMPLE_BITS'(int'($urandom_range(0, 64)) - 32768);
			default: return SAMPLE_BITS'($urandom);
		endcase
	endfunction

	// random phase: optional leading clear, then mostly pushes
	task automatic queue_random_phase(input int count, input bit lead_clear,
			input int clear_odds);
		int unsigned phase_style;
		int unsigned style;
		logic        op;
		phase_style = $urandom_range(0, 4);
		for (int k = 0; k < count; k++) begin
			style = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4) : phase_style;
			if (lead_clear && k == 0)
				op = OP_CLEAR;
			else if (clear_odds > 0 && $urandom_range(1, clear_odds) == 1)
				op = OP_CLEAR;
			else
				op = OP_PUSH;
			queue_item(op, pick_sample(style));
		end
	endtask

	// wait until every queued beat is taken and every result has come back
	task automatic wait_idle();
		while (items_accepted != items_queued || stats_due.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_length(input logic [LEN_BITS-1:0] value);
		int seen;
		wait_idle();
		seen = cfg_writes;
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do
			@(negedge clk);
		while (cfg_writes == seen);
		cfg_valid <= 1'b0;
	endtask

	initial begin : stimulus
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: extremes at the reset length, first with the window still zero-filled, then after clears
		queue_item(OP_PUSH, 16'sh7FFF);
		queue_item(OP_PUSH, 16'sh8000);
		queue_item(OP_PUSH, 16'sh0000);
		queue_item(OP_PUSH, -16'sd1);
		queue_item(OP_PUSH, 16'sd1);
		queue_item(OP_PUSH, 16'sh5555);
		queue_item(OP_PUSH, 16'shAAAA);
		queue_item(OP_CLEAR, 16'sh8000);
		queue_item(OP_PUSH, 16'sh7FFF);
		queue_item(OP_PUSH, 16'sh8000);
		queue_item(OP_CLEAR, 16'sh7FFF);
		queue_item(OP_PUSH, 16'sh0000);
		queue_item(OP_CLEAR, 16'sh0000);
		queue_item(OP_PUSH, -16'sd5);

		// single-sample window, changed without a clear
		write_length(LEN_BITS'(1));
		queue_item(OP_PUSH, 16'sh7FFF);
		queue_item(OP_PUSH, 16'sh8000);
		// zero length acts as one sample
		write_length(LEN_BITS'(0));
		queue_item(OP_PUSH, 16'sd3);
		queue_item(OP_PUSH, -16'sd3);
		// lengths above capacity saturate to the full ring
		write_length(LEN_BITS'(4095));
		queue_item(OP_PUSH, 16'sd100);
		write_length(LEN_BITS'(2048));
		queue_item(OP_PUSH, -16'sd100);

		// random: long windows first, few beats since each one scans the ring
		write_length(LEN_BITS'(2049));
		queue_random_phase(3, 1'b0, 0);
		write_length(LEN_BITS'(2048));
		queue_random_phase(4, 1'b0, 0);
		write_length(LEN_BITS'(1));
		queue_random_phase(25, 1'b1, 12);
		write_length(LEN_BITS'(2));
		queue_random_phase(25, 1'b0, 12);

		// hold off the receiver so the block backs up into its input
		write_length(LEN_BITS'(4));
		queue_random_phase(15, 1'b0, 0);
		holdoff_requests++;

		for (int p = 0; p < 9; p++) begin
			write_length(LEN_BITS'($urandom_range(3, 64)));
			idle_on = ($urandom_range(0, 3) != 0);
			queue_random_phase(20, 1'($urandom_range(0, 1)), 12);
		end

		write_length(LEN_BITS'(600));
		idle_on = 1'b1;
		queue_random_phase(8, 1'b0, 0);
		write_length(LEN_BITS'($urandom_range(900, 1100)));
		queue_random_phase(5, 1'b1, 0);

		// last stretch runs at full rate on both sides
		write_length(LEN_BITS'($urandom_range(5, 40)));
		idle_on = 1'b0;
		queue_random_phase(25, 1'b1, 12);

		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (stats_due.size() != 0)
			flag_error($sformatf("%0d results never arrived", stats_due.size()));
		if (errors == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
